// ===== design/rptw_pkg.sv =====
// Shared types, field widths and codes for the radix page table walker.
`timescale 1ns / 1ps
package rptw_pkg;

    // Field widths of the request, response and configuration words
    localparam int CMD_W      = 2;
    localparam int VPN_W      = 45;
    localparam int PPN_W      = 52;
    localparam int ENT_W      = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int INDEX_BITS = 9;
    localparam int ROOT_W     = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    // Defaults for the top-level parameters
    localparam int FRAMES_DEF = 64;
    localparam int LEVELS_DEF = 5;

    // Reset value of the allocator pointer
    localparam int FIRST_FREE_RST = 1;

    // Leaf entry written by a remove: valid bit clear, marker bit set
    localparam logic [ENT_W-1:0] ENT_REMOVED = 64'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROOT_FRAME = 1'b0,
        REG_FIRST_FREE = 1'b1
    } t_reg_idx;

    // Request commands; the fourth code is a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_MAP    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    // Walker sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

endpackage

// ===== design/rptw_ifs.sv =====
// Valid/ready channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps

interface rptw_req_if;
    logic                        valid;
    logic                        ready;
    logic [rptw_pkg::CMD_W-1:0]  command;
    logic [rptw_pkg::VPN_W-1:0]  virtual_page;
    logic [rptw_pkg::PPN_W-1:0]  physical_page;

    modport source (output valid, command, virtual_page, physical_page, input ready);
    modport sink   (input valid, command, virtual_page, physical_page, output ready);
endinterface

interface rptw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        mapped;
    logic [rptw_pkg::PPN_W-1:0]  result_page;
    logic                        out_of_frames;

    modport source (output valid, mapped, result_page, out_of_frames, input ready);
    modport sink   (input valid, mapped, result_page, out_of_frames, output ready);
endinterface

interface rptw_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rptw_pkg::CFG_IDX_W-1:0]   index;
    logic [rptw_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/radix_page_table_walker.sv =====
// Radix page table walker: frame memory, walk sequencer and response register.
//
//   channel  dir  handshake        word
//   i_cfg    in   valid/ready      index, data (root frame, first free frame)
//   i_req    in   valid/ready      command, virtual_page, physical_page
//   o_rsp    out  valid/ready      mapped, result_page, out_of_frames
//
// Each level of a request takes a read of the frame memory (S_READ) and a check of
// the entry with the write-back of an allocated node or the leaf (S_EVAL); a walk
// that ends early is shorter.
// After reset the frame memory is cleared one entry a cycle, all FRAMES*512 entries
// (32768 by default); no request is taken meanwhile, configuration writes are.
// The response register lets the next request enter while a word waits on o_rsp.
`timescale 1ns / 1ps
module radix_page_table_walker #(
    parameter int FRAMES = rptw_pkg::FRAMES_DEF,
    parameter int LEVELS = rptw_pkg::LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rptw_cfg_if.sink    i_cfg,
    rptw_req_if.sink    i_req,
    rptw_rsp_if.source  o_rsp
);
    import rptw_pkg::*;

    localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int AW    = FW + INDEX_BITS;
    localparam int DEPTH = FRAMES << INDEX_BITS;
    localparam int LW    = $clog2(LEVELS);
    localparam int NF_W  = ($clog2(FRAMES + 1) > CFG_DATA_W) ? $clog2(FRAMES + 1) : CFG_DATA_W;
    localparam int FF_W  = ENT_W - PAGE_SHIFT;

    // Frame memory
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] r_rd_data;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [ENT_W-1:0] mem_wd;
    logic [AW-1:0]    mem_ra;

    // Control and walk state
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [LW-1:0]     r_level, n_level;
    logic [FW-1:0]     r_frame, n_frame;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [VPN_W-1:0]  r_vpn, n_vpn;
    logic [PPN_W-1:0]  r_ppn, n_ppn;
    logic [NF_W-1:0]   r_next_free, n_next_free;
    logic [ROOT_W-1:0] r_root, n_root;

    // Finished result and response register
    logic              r_res_mapped, n_res_mapped;
    logic [PPN_W-1:0]  r_res_page, n_res_page;
    logic              r_res_oof, n_res_oof;
    logic              r_out_valid, n_out_valid;
    logic              r_out_mapped, n_out_mapped;
    logic [PPN_W-1:0]  r_out_page, n_out_page;
    logic              r_out_oof, n_out_oof;

    // Entry decode
    logic [5:0]          lvl_rem;
    logic [5:0]          lvl_shift;
    logic [INDEX_BITS-1:0] slot_idx;
    logic [FF_W-1:0]     ent_frame;
    logic                ent_frame_ok;
    logic                ent_zero;
    logic                is_last;
    logic                nf_ok;
    logic                root_ok;
    logic                req_acc;
    logic                cfg_we;
    logic                alloc;

    assign req_acc     = i_req.valid && i_req.ready;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.mapped        = r_out_mapped;
    assign o_rsp.result_page   = r_out_page;
    assign o_rsp.out_of_frames = r_out_oof;

    // Slot index of the current level, most significant index first
    assign lvl_rem   = 6'(LEVELS - 1) - 6'(r_level);
    assign lvl_shift = lvl_rem * 6'(INDEX_BITS);
    assign slot_idx  = r_vpn[lvl_shift +: INDEX_BITS];
    assign mem_ra    = {r_frame, slot_idx};

    assign ent_frame    = r_rd_data[ENT_W-1:PAGE_SHIFT];
    assign ent_frame_ok = ent_frame < FF_W'(FRAMES);
    assign ent_zero     = (r_rd_data == '0);
    assign is_last      = (r_level == LW'(LEVELS - 1));
    assign nf_ok        = r_next_free < NF_W'(FRAMES);
    assign root_ok      = 32'(r_root) < 32'(FRAMES);

    // Sequencer, datapath and register file next values
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_level      = r_level;
        n_frame      = r_frame;
        n_cmd        = r_cmd;
        n_vpn        = r_vpn;
        n_ppn        = r_ppn;
        n_next_free  = r_next_free;
        n_root       = r_root;
        n_res_mapped = r_res_mapped;
        n_res_page   = r_res_page;
        n_res_oof    = r_res_oof;
        n_out_valid  = r_out_valid;
        n_out_mapped = r_out_mapped;
        n_out_page   = r_out_page;
        n_out_oof    = r_out_oof;
        mem_we       = 1'b0;
        mem_wa       = mem_ra;
        mem_wd       = '0;
        alloc        = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_wa     = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_cmd        = i_req.command;
                    n_vpn        = i_req.virtual_page;
                    n_ppn        = i_req.physical_page;
                    n_frame      = FW'(r_root);
                    n_level      = '0;
                    n_res_mapped = 1'b0;
                    n_res_page   = '0;
                    n_res_oof    = 1'b0;
                    if (root_ok && (i_req.command == CMD_QUERY ||
                                    i_req.command == CMD_MAP ||
                                    i_req.command == CMD_REMOVE)) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DONE;
                if (r_cmd == CMD_QUERY) begin
                    // query: valid bit must be set at every level
                    if (is_last) begin
                        n_res_mapped = r_rd_data[0];
                        n_res_page   = r_rd_data[0] ? ent_frame : '0;
                    end else if (r_rd_data[0] && ent_frame_ok) begin
                        n_frame = FW'(ent_frame);
                        n_level = r_level + 1'b1;
                        n_state = S_READ;
                    end
                end else if (is_last) begin
                    // leaf update
                    mem_we = 1'b1;
                    mem_wd = (r_cmd == CMD_REMOVE) ? ENT_REMOVED
                                                   : {r_ppn, {(PAGE_SHIFT-1){1'b0}}, 1'b1};
                end else if (!ent_zero) begin
                    if (ent_frame_ok) begin
                        n_frame = FW'(ent_frame);
                        n_level = r_level + 1'b1;
                        n_state = S_READ;
                    end
                end else if (r_cmd == CMD_MAP) begin
                    // missing node: take a frame from the allocator
                    if (nf_ok) begin
                        alloc       = 1'b1;
                        mem_we      = 1'b1;
                        mem_wd      = {FF_W'(r_next_free), {(PAGE_SHIFT-1){1'b0}}, 1'b1};
                        n_next_free = r_next_free + 1'b1;
                        n_frame     = FW'(r_next_free);
                        n_level     = r_level + 1'b1;
                        n_state     = S_READ;
                    end else begin
                        n_res_oof = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_mapped = r_res_mapped;
                    n_out_page   = r_res_page;
                    n_out_oof    = r_res_oof;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration writes; first free frame also reloads the allocator
        if (cfg_we) begin
            case (i_cfg.index)
                REG_ROOT_FRAME: n_root      = i_cfg.data[ROOT_W-1:0];
                REG_FIRST_FREE: n_next_free = NF_W'(i_cfg.data);
                default:        n_root      = r_root;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= NF_W'(FIRST_FREE_RST);
            r_root      <= '0;
            r_out_valid <= 1'b0;
            r_level     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_next_free <= n_next_free;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
            r_level     <= n_level;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_frame      <= n_frame;
        r_cmd        <= n_cmd;
        r_vpn        <= n_vpn;
        r_ppn        <= n_ppn;
        r_res_mapped <= n_res_mapped;
        r_res_page   <= n_res_page;
        r_res_oof    <= n_res_oof;
        r_out_mapped <= n_out_mapped;
        r_out_page   <= n_out_page;
        r_out_oof    <= n_out_oof;
    end

    // Frame memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

`ifndef NO_ASSERTIONS
    // a query never writes the table
    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_cmd == CMD_QUERY) |-> !mem_we)
        else $error("table written during a query");

    // allocation advances the pointer by exactly one
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (alloc && !cfg_we) |=> (r_next_free == $past(r_next_free) + 1'b1))
        else $error("allocator pointer did not advance by one");

    // the pointer only moves on allocation or reload
    a_nf_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!alloc && !cfg_we) |=> $stable(r_next_free))
        else $error("allocator pointer moved without allocation");

    // a response never reports both a mapping and exhaustion
    a_rsp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_mapped && r_out_oof))
        else $error("response flags mapped and out_of_frames together");

    // the walk level stays within the table depth
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_EVAL) |-> (32'(r_level) < 32'(LEVELS)))
        else $error("walk level out of range");
`endif

endmodule
